@@ sv/kdr_pkg.sv @@
`default_nettype none

package kdr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 3;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_TIME   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_TIME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_TIME = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MIN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MAX   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE = 3'd6;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_PUSH        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REPEAT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UP          = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOWN        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UP_REPEAT   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DOWN_REPEAT = 3'd6;

    // register reset values
    localparam int DEAD_TIME_RESET   = 50;
    localparam int REPEAT_TIME_RESET = 50;
    localparam int COUNT_MAX_RESET   = 100;

endpackage

`default_nettype wire

@@ sv/kdr_if.sv @@
`default_nettype none

interface kdr_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

interface kdr_res_if #(parameter int COUNT_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic                         event_res;
    logic signed [COUNT_BITS-1:0] counter_value;

    modport source (output valid, output event_res, output counter_value, input ready);
    modport sink   (input valid, input event_res, input counter_value, output ready);
endinterface

interface kdr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kdr_pkg::CFG_INDEX_W-1:0] index;
    logic [kdr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/key_debounce_repeat_counter.sv @@
// key debounce with auto-repeat and a stepped up/down counter
//
// key: one sampled key level per word, normally one word per millisecond tick.
// res: one word back for every key word: event_res pulses when an action fires
//   on that tick, counter_value is the stored counter after the tick.
// cfg: register writes (mode, dead_time, accept_time, repeat_time, count_min,
//   count_max, wrap_enable), always ready; write only while the block is idle.
// throughput: one key word per cycle while key.ready is high; the debounce state,
//   the tick counters and the counter step are all updated from the incoming word.
// the result goes into an output register backed by one skid register, so a
//   new key word is still taken while one result waits; key.ready drops only
//   when both hold results, and rises again once res takes a word.
// reset: registers return to their defaults, counter is zero, both result
//   registers are empty, and the block first waits for a released sample
//   before it looks for a press.
`default_nettype none

module key_debounce_repeat_counter #(
    parameter int TIME_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    kdr_cfg_if.sink    cfg,
    kdr_key_if.sink    key,
    kdr_res_if.source  res
);

    localparam int PT_W = TIME_BITS + 1;
    localparam int CW   = COUNT_BITS;

    localparam logic [2:0] PH_WAIT_REL    = 3'd0;
    localparam logic [2:0] PH_IDLE        = 3'd1;
    localparam logic [2:0] PH_QUALIFY     = 3'd2;
    localparam logic [2:0] PH_HOLD        = 3'd3;
    localparam logic [2:0] PH_REPEAT      = 3'd4;
    localparam logic [2:0] PH_REL_WAIT    = 3'd5;
    localparam logic [2:0] PH_ACCEPT_WAIT = 3'd6;

    // configuration registers
    logic [kdr_pkg::MODE_W-1:0] mode_reg;
    logic [TIME_BITS-1:0]       dead_time_reg;
    logic [TIME_BITS-1:0]       accept_time_reg;
    logic [TIME_BITS-1:0]       repeat_time_reg;
    logic signed [CW-1:0]       count_min_reg;
    logic signed [CW-1:0]       count_max_reg;
    logic                       wrap_enable_reg;

    // debounce state
    logic [2:0]           phase_reg, phase_next;
    logic [PT_W-1:0]      press_ticks_reg, press_ticks_next;
    logic [TIME_BITS-1:0] repeat_ticks_reg, repeat_ticks_next;
    logic signed [CW-1:0] count_reg, count_next;

    // result registers
    logic                 out_valid_reg;
    logic                 out_event_reg;
    logic signed [CW-1:0] out_count_reg;
    logic                 skid_valid_reg;
    logic                 skid_event_reg;
    logic signed [CW-1:0] skid_count_reg;

    logic                 take;
    logic                 pop;
    logic                 count_rep;
    logic                 act;
    logic                 ev;
    logic [PT_W-1:0]      pt_inc;
    logic [TIME_BITS-1:0] rt_inc;
    logic signed [CW:0]   v_ext;
    logic signed [CW:0]   lo_ext;
    logic signed [CW:0]   hi_ext;
    logic signed [CW:0]   up_ext;
    logic signed [CW:0]   dn_ext;
    logic signed [CW-1:0] up_val;
    logic signed [CW-1:0] dn_val;

    assign cfg.ready = 1'b1;
    assign key.ready = !skid_valid_reg;
    assign take      = key.valid && key.ready;
    assign pop       = out_valid_reg && res.ready;

    assign res.valid         = out_valid_reg;
    assign res.event_res     = out_event_reg;
    assign res.counter_value = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= kdr_pkg::MODE_PUSH;
            dead_time_reg   <= TIME_BITS'(kdr_pkg::DEAD_TIME_RESET);
            accept_time_reg <= '0;
            repeat_time_reg <= TIME_BITS'(kdr_pkg::REPEAT_TIME_RESET);
            count_min_reg   <= '0;
            count_max_reg   <= CW'(kdr_pkg::COUNT_MAX_RESET);
            wrap_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                kdr_pkg::REG_MODE:        mode_reg        <= cfg.data[kdr_pkg::MODE_W-1:0];
                kdr_pkg::REG_DEAD_TIME:   dead_time_reg   <= cfg.data[TIME_BITS-1:0];
                kdr_pkg::REG_ACCEPT_TIME: accept_time_reg <= cfg.data[TIME_BITS-1:0];
                kdr_pkg::REG_REPEAT_TIME: repeat_time_reg <= cfg.data[TIME_BITS-1:0];
                kdr_pkg::REG_COUNT_MIN:   count_min_reg   <= cfg.data[CW-1:0];
                kdr_pkg::REG_COUNT_MAX:   count_max_reg   <= cfg.data[CW-1:0];
                kdr_pkg::REG_WRAP_ENABLE: wrap_enable_reg <= cfg.data[0];
                default:                  ;
            endcase
        end
    end

    // counter step candidates, one bit wider so +1 / -1 cannot overflow
    always_comb
    begin
        v_ext  = {count_reg[CW-1], count_reg};
        lo_ext = {count_min_reg[CW-1], count_min_reg};
        hi_ext = {count_max_reg[CW-1], count_max_reg};
        up_ext = v_ext + (CW+1)'(1);
        dn_ext = v_ext - (CW+1)'(1);
        if (wrap_enable_reg)
        begin
            up_val = (up_ext > hi_ext) ? count_min_reg : up_ext[CW-1:0];
            dn_val = (dn_ext < lo_ext) ? count_max_reg : dn_ext[CW-1:0];
        end
        else
        begin
            up_val = (count_reg < count_max_reg) ? up_ext[CW-1:0] : count_reg;
            dn_val = (count_reg > count_min_reg) ? dn_ext[CW-1:0] : count_reg;
        end
    end

    always_comb
    begin
        count_rep = (mode_reg == kdr_pkg::MODE_UP_REPEAT) ||
                    (mode_reg == kdr_pkg::MODE_DOWN_REPEAT);
        pt_inc = (press_ticks_reg == {PT_W{1'b1}}) ? press_ticks_reg
                                                   : press_ticks_reg + PT_W'(1);
        rt_inc = (repeat_ticks_reg == {TIME_BITS{1'b1}}) ? repeat_ticks_reg
                                                         : repeat_ticks_reg + TIME_BITS'(1);
        phase_next        = phase_reg;
        press_ticks_next  = press_ticks_reg;
        repeat_ticks_next = repeat_ticks_reg;
        act               = 1'b0;
        ev                = 1'b0;

        unique case (phase_reg)
            PH_WAIT_REL:
            begin
                if (!key.key_level)
                    phase_next = PH_IDLE;
            end
            PH_IDLE:
            begin
                if (key.key_level)
                begin
                    press_ticks_next = '0;
                    if (count_rep)
                        phase_next = PH_ACCEPT_WAIT;
                    else if (dead_time_reg == '0)
                    begin
                        // zero dead time accepts on the press tick itself
                        if (mode_reg == kdr_pkg::MODE_RELEASE)
                            phase_next = PH_REL_WAIT;
                        else if (mode_reg == kdr_pkg::MODE_PUSH_REPEAT)
                        begin
                            phase_next        = PH_REPEAT;
                            repeat_ticks_next = '0;
                            act               = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                            act        = 1'b1;
                        end
                    end
                    else
                        phase_next = PH_QUALIFY;
                end
            end
            PH_QUALIFY:
            begin
                press_ticks_next = pt_inc;
                if (!key.key_level)
                    phase_next = PH_IDLE;
                else if (pt_inc >= PT_W'(dead_time_reg))
                begin
                    if (mode_reg == kdr_pkg::MODE_RELEASE)
                        phase_next = PH_REL_WAIT;
                    else if (mode_reg == kdr_pkg::MODE_PUSH_REPEAT || count_rep)
                    begin
                        phase_next        = PH_REPEAT;
                        repeat_ticks_next = '0;
                        act               = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HOLD;
                        act        = 1'b1;
                    end
                end
            end
            PH_ACCEPT_WAIT:
            begin
                press_ticks_next = pt_inc;
                if (!key.key_level)
                begin
                    // short press still steps once when past the dead time
                    act        = (pt_inc > PT_W'(dead_time_reg));
                    phase_next = PH_IDLE;
                end
                else if (pt_inc >= PT_W'(accept_time_reg))
                begin
                    act               = 1'b1;
                    phase_next        = PH_REPEAT;
                    repeat_ticks_next = '0;
                end
            end
            PH_REPEAT:
            begin
                if (!key.key_level)
                    phase_next = PH_IDLE;
                else if (rt_inc >= repeat_time_reg)
                begin
                    act               = 1'b1;
                    repeat_ticks_next = '0;
                end
                else
                    repeat_ticks_next = rt_inc;
            end
            PH_REL_WAIT:
            begin
                if (!key.key_level)
                begin
                    ev         = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (!key.key_level)
                    phase_next = PH_IDLE;
            end
        endcase

        if (act)
            ev = 1'b1;

        count_next = count_reg;
        if (act)
        begin
            if (mode_reg == kdr_pkg::MODE_UP || mode_reg == kdr_pkg::MODE_UP_REPEAT)
                count_next = up_val;
            else if (mode_reg == kdr_pkg::MODE_DOWN || mode_reg == kdr_pkg::MODE_DOWN_REPEAT)
                count_next = dn_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT_REL;
            press_ticks_reg  <= '0;
            repeat_ticks_reg <= '0;
            count_reg        <= '0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            press_ticks_reg  <= press_ticks_next;
            repeat_ticks_reg <= repeat_ticks_next;
            count_reg        <= count_next;
        end
    end

    // output register with one skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= take;
            end
            else
                out_valid_reg <= take;
        end
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_event_reg  <= skid_event_reg;
                out_count_reg  <= skid_count_reg;
                skid_event_reg <= ev;
                skid_count_reg <= count_next;
            end
            else
            begin
                out_event_reg <= ev;
                out_count_reg <= count_next;
            end
        end
        else if (take)
        begin
            skid_event_reg <= ev;
            skid_count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/kdr_checker.sv @@
`default_nettype none

module kdr_checker #(
    parameter int COUNT_BITS = 16
) (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire                         out_event,
    input wire signed [COUNT_BITS-1:0] out_count
);

    logic                         seen_reg;
    logic signed [COUNT_BITS-1:0] last_count_reg;

    // counter value of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (out_valid && out_ready)
            seen_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
            last_count_reg <= out_count;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_count))
        else $error("result word changed while stalled");

    a_full_means_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("key input stalled with no result waiting");

    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid && !out_ready |=> out_valid && !in_ready)
        else $error("word taken during stall was not parked");

    a_count_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && seen_reg && !out_event |-> out_count == last_count_reg)
        else $error("counter moved without an event");

endmodule

bind key_debounce_repeat_counter kdr_checker #(.COUNT_BITS(COUNT_BITS)) u_kdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key.valid),
    .in_ready  (key.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_event (res.event_res),
    .out_count (res.counter_value)
);

`default_nettype wire
